[src/cnms_pkg.sv]
// Package for class-aware box NMS: sizes, register indexes, reset values.
// Used by class_aware_box_nms_top.
`timescale 1ns / 1ps
`default_nettype none
package cnms_pkg;
   localparam int MAX_BOXES   = 256;
   localparam int ADDR_W      = $clog2(MAX_BOXES);
   localparam int CNT_W       = $clog2(MAX_BOXES + 1);
   localparam int MAX_KEPT    = 64;
   localparam int KEPT_W      = 7;
   localparam int CLASS_COUNT = 6;
   localparam int BOX_W       = 64;
   localparam int TAG_W       = 19;
   localparam int COORD_W     = 16;
   localparam int SHIFT_W     = 20;
   localparam int POS_W       = 23;
   localparam int PROD_W      = 53;

   typedef enum logic [1:0] {
      CSR_CLASS_SHIFT     = 2'd0,
      CSR_OVERLAP_LIMIT   = 2'd1,
      CSR_CANDIDATE_LIMIT = 2'd2,
      CSR_KEEP_LIMIT      = 2'd3
   } csr_index_type;

   localparam logic [19:0] RST_CLASS_SHIFT     = 20'd122880;
   localparam logic [15:0] RST_OVERLAP_LIMIT   = 16'd29491;
   localparam logic [8:0]  RST_CANDIDATE_LIMIT = 9'd256;
   localparam logic [6:0]  RST_KEEP_LIMIT      = 7'd64;
endpackage
`default_nettype wire

[src/cnms_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module cnms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[src/class_aware_box_nms_top.sv]
// Class-aware greedy NMS over one set of sorted boxes, shared multiplier loop.
// Depends on cnms_pkg and cnms_ram.
// Loading: one box per cycle; a box is taken when start is high and busy is low.
// After the set-end beat, each candidate visit reads and checks a box; a kept box has its
// offset corners and area registered, and each later box not already suppressed gets a
// pairwise overlap test (one shared 33x20 multiplier used four times per pair).
// Busy drops in the cycle of the final beat; the receiver cannot stall results.
// Reset (synchronous, active high) clears set state and registers to defaults;
// suppress flags are cleared as each box is stored.
`timescale 1ns / 1ps
`default_nettype none
module class_aware_box_nms_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_class_index,
   input  wire logic [15:0] req_left,
   input  wire logic [15:0] req_top,
   input  wire logic [15:0] req_right,
   input  wire logic [15:0] req_bottom,
   input  wire logic [15:0] req_score,
   input  wire logic        req_set_end,
   output logic             rsp_strobe,
   output logic             rsp_present,
   output logic             rsp_status,
   output logic [2:0]       rsp_kept_class,
   output logic [15:0]      rsp_kept_left,
   output logic [15:0]      rsp_kept_top,
   output logic [15:0]      rsp_kept_right,
   output logic [15:0]      rsp_kept_bottom,
   output logic [15:0]      rsp_kept_score,
   output logic             rsp_final_res,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [19:0] csr_wdata
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_RDI, ST_CHKI, ST_KA, ST_KB, ST_RDJ, ST_CHKJ,
      ST_GEOM, ST_IWH, ST_INT, ST_UNI, ST_THR, ST_DEC, ST_FIN
   } state_type;

   localparam int AW = cnms_pkg::ADDR_W;
   localparam int CW = cnms_pkg::CNT_W;
   localparam int PW = cnms_pkg::POS_W;

   state_type state_ff;
   logic [19:0] shift_ff;
   logic [15:0] thr_ff;
   logic [8:0]  cand_ff;
   logic [6:0]  keep_ff;

   logic [CW-1:0] loaded_ff, i_ff, j_ff;
   logic          bad_ff;
   logic [cnms_pkg::KEPT_W-1:0] kept_ff;

   logic          pend_valid_ff;
   logic [63:0]   pend_box_ff;
   logic [18:0]   pend_tag_ff;
   logic [63:0]   b_raw_ff;
   logic [PW-1:0] a_x1_ff, a_y1_ff, a_x2_ff, a_y2_ff;
   logic [PW-1:0] b_x1_ff, b_y1_ff, b_x2_ff, b_y2_ff;
   logic [31:0]   aa_ff, ab_ff, inter_ff;
   logic [32:0]   uni_ff;
   logic [15:0]   iw_ff, ih_ff;
   logic [cnms_pkg::PROD_W-1:0] prod_ff;

   logic rsp_strobe_ff, rsp_present_ff, rsp_status_ff, rsp_final_ff;
   logic [2:0]  rsp_class_ff;
   logic [15:0] rsp_left_ff, rsp_top_ff, rsp_right_ff, rsp_bottom_ff, rsp_score_ff;

   logic [63:0] box_rd;
   logic [18:0] tag_rd;
   logic [0:0]  supp_rd;
   logic [AW-1:0] rd_addr;
   logic accept, store, bad_in;
   logic supp_hit, supp_we, supp_wr;
   logic [AW-1:0] supp_addr;
   logic [CW-1:0] lim;
   logic [cnms_pkg::KEPT_W-1:0] keep_lim;
   logic [32:0] mul_a;
   logic [19:0] mul_b;
   logic [cnms_pkg::PROD_W-1:0] prod_in;
   logic [PW-1:0] mx1, my1, nx2, ny2;
   logic [15:0] iw_in, ih_in;
   logic [47:0] inter_sh;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign lim    = (cand_ff > 9'(cnms_pkg::MAX_BOXES)) ? CW'(cnms_pkg::MAX_BOXES)
                                                       : CW'(cand_ff);
   assign store  = accept && (loaded_ff < lim);
   assign bad_in = (req_class_index >= 3'(cnms_pkg::CLASS_COUNT)) ||
                   (req_right <= req_left) || (req_bottom <= req_top);
   assign keep_lim = (keep_ff == 7'd0) ? 7'd1 :
                     (keep_ff > 7'(cnms_pkg::MAX_KEPT)) ? 7'(cnms_pkg::MAX_KEPT) : keep_ff;
   assign rd_addr = (state_ff == ST_RDJ) ? j_ff[AW-1:0] : i_ff[AW-1:0];

   cnms_ram #(.WIDTH(cnms_pkg::BOX_W), .DEPTH(cnms_pkg::MAX_BOXES)) u_box_ram (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (loaded_ff[AW-1:0]),
      .wr_data ({req_bottom, req_right, req_top, req_left}),
      .rd_addr (rd_addr),
      .rd_data (box_rd)
   );

   cnms_ram #(.WIDTH(cnms_pkg::TAG_W), .DEPTH(cnms_pkg::MAX_BOXES)) u_tag_ram (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (loaded_ff[AW-1:0]),
      .wr_data ({req_class_index, req_score}),
      .rd_addr (rd_addr),
      .rd_data (tag_rd)
   );

   // flag cleared on load, set on suppression
   assign supp_hit  = (state_ff == ST_DEC) && (cnms_pkg::PROD_W'(inter_sh) > prod_ff);
   assign supp_we   = store || supp_hit;
   assign supp_addr = store ? loaded_ff[AW-1:0] : j_ff[AW-1:0];
   assign supp_wr   = !store;

   cnms_ram #(.WIDTH(1), .DEPTH(cnms_pkg::MAX_BOXES)) u_supp_ram (
      .clock   (clock),
      .wr_en   (supp_we),
      .wr_addr (supp_addr),
      .wr_data (supp_wr),
      .rd_addr (rd_addr),
      .rd_data (supp_rd)
   );

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_CHKI, ST_CHKJ: begin
            mul_a = 33'(tag_rd[18:16]);
            mul_b = shift_ff;
         end
         ST_KA: begin
            mul_a = 33'(pend_box_ff[47:32] - pend_box_ff[15:0]);
            mul_b = 20'(pend_box_ff[63:48] - pend_box_ff[31:16]);
         end
         ST_GEOM: begin
            mul_a = 33'(b_raw_ff[47:32] - b_raw_ff[15:0]);
            mul_b = 20'(b_raw_ff[63:48] - b_raw_ff[31:16]);
         end
         ST_INT: begin
            mul_a = 33'(iw_ff);
            mul_b = 20'(ih_ff);
         end
         ST_THR: begin
            mul_a = uni_ff;
            mul_b = 20'(thr_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod_in = cnms_pkg::PROD_W'(mul_a) * cnms_pkg::PROD_W'(mul_b);

   assign mx1 = (a_x1_ff > b_x1_ff) ? a_x1_ff : b_x1_ff;
   assign my1 = (a_y1_ff > b_y1_ff) ? a_y1_ff : b_y1_ff;
   assign nx2 = (a_x2_ff < b_x2_ff) ? a_x2_ff : b_x2_ff;
   assign ny2 = (a_y2_ff < b_y2_ff) ? a_y2_ff : b_y2_ff;
   assign iw_in = (nx2 > mx1) ? 16'(nx2 - mx1) : 16'd0;
   assign ih_in = (ny2 > my1) ? 16'(ny2 - my1) : 16'd0;
   assign inter_sh = {inter_ff, 16'd0};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         shift_ff      <= cnms_pkg::RST_CLASS_SHIFT;
         thr_ff        <= cnms_pkg::RST_OVERLAP_LIMIT;
         cand_ff       <= cnms_pkg::RST_CANDIDATE_LIMIT;
         keep_ff       <= cnms_pkg::RST_KEEP_LIMIT;
         loaded_ff     <= '0;
         bad_ff        <= 1'b0;
         kept_ff       <= '0;
         pend_valid_ff <= 1'b0;
         i_ff          <= '0;
         j_ff          <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (csr_wr_en) begin
            case (csr_index)
               cnms_pkg::CSR_CLASS_SHIFT:     shift_ff <= csr_wdata;
               cnms_pkg::CSR_OVERLAP_LIMIT:   thr_ff   <= csr_wdata[15:0];
               cnms_pkg::CSR_CANDIDATE_LIMIT: cand_ff  <= csr_wdata[8:0];
               cnms_pkg::CSR_KEEP_LIMIT:      keep_ff  <= csr_wdata[6:0];
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (store) begin
                     loaded_ff <= loaded_ff + 1'b1;
                     bad_ff    <= bad_ff | bad_in;
                  end
                  if (req_set_end) begin
                     state_ff <= ST_PREP;
                  end
               end
            end
            ST_PREP: begin
               i_ff          <= '0;
               pend_valid_ff <= 1'b0;
               if (bad_ff) begin
                  rsp_strobe_ff  <= 1'b1;
                  rsp_present_ff <= 1'b0;
                  rsp_status_ff  <= 1'b1;
                  rsp_final_ff   <= 1'b1;
                  rsp_class_ff   <= '0;
                  rsp_left_ff    <= '0;
                  rsp_top_ff     <= '0;
                  rsp_right_ff   <= '0;
                  rsp_bottom_ff  <= '0;
                  rsp_score_ff   <= '0;
                  loaded_ff      <= '0;
                  bad_ff         <= 1'b0;
                  kept_ff        <= '0;
                  state_ff       <= ST_IDLE;
               end else begin
                  state_ff <= ST_RDI;
               end
            end
            ST_RDI: begin
               state_ff <= (i_ff >= loaded_ff) ? ST_FIN : ST_CHKI;
            end
            ST_CHKI: begin
               if (supp_rd[0]) begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= ST_RDI;
               end else begin
                  if (pend_valid_ff) begin
                     rsp_strobe_ff  <= 1'b1;
                     rsp_present_ff <= 1'b1;
                     rsp_status_ff  <= 1'b0;
                     rsp_final_ff   <= 1'b0;
                     rsp_class_ff   <= pend_tag_ff[18:16];
                     rsp_left_ff    <= pend_box_ff[15:0];
                     rsp_top_ff     <= pend_box_ff[31:16];
                     rsp_right_ff   <= pend_box_ff[47:32];
                     rsp_bottom_ff  <= pend_box_ff[63:48];
                     rsp_score_ff   <= pend_tag_ff[15:0];
                  end
                  pend_valid_ff <= 1'b1;
                  pend_box_ff   <= box_rd;
                  pend_tag_ff   <= tag_rd;
                  kept_ff       <= kept_ff + 1'b1;
                  state_ff      <= ((kept_ff + 1'b1) >= keep_lim) ? ST_FIN : ST_KA;
               end
            end
            ST_KA: begin
               a_x1_ff  <= PW'(pend_box_ff[15:0])  + prod_ff[PW-1:0];
               a_y1_ff  <= PW'(pend_box_ff[31:16]) + prod_ff[PW-1:0];
               a_x2_ff  <= PW'(pend_box_ff[47:32]) + prod_ff[PW-1:0];
               a_y2_ff  <= PW'(pend_box_ff[63:48]) + prod_ff[PW-1:0];
               state_ff <= ST_KB;
            end
            ST_KB: begin
               aa_ff    <= prod_ff[31:0];
               j_ff     <= i_ff + 1'b1;
               state_ff <= ST_RDJ;
            end
            ST_RDJ: begin
               if (j_ff >= loaded_ff) begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= ST_RDI;
               end else begin
                  state_ff <= ST_CHKJ;
               end
            end
            ST_CHKJ: begin
               if (supp_rd[0]) begin
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= ST_RDJ;
               end else begin
                  b_raw_ff <= box_rd;
                  state_ff <= ST_GEOM;
               end
            end
            ST_GEOM: begin
               b_x1_ff  <= PW'(b_raw_ff[15:0])  + prod_ff[PW-1:0];
               b_y1_ff  <= PW'(b_raw_ff[31:16]) + prod_ff[PW-1:0];
               b_x2_ff  <= PW'(b_raw_ff[47:32]) + prod_ff[PW-1:0];
               b_y2_ff  <= PW'(b_raw_ff[63:48]) + prod_ff[PW-1:0];
               state_ff <= ST_IWH;
            end
            ST_IWH: begin
               ab_ff    <= prod_ff[31:0];
               iw_ff    <= iw_in;
               ih_ff    <= ih_in;
               state_ff <= ST_INT;
            end
            ST_INT: begin
               state_ff <= ST_UNI;
            end
            ST_UNI: begin
               inter_ff <= prod_ff[31:0];
               uni_ff   <= 33'(aa_ff) + 33'(ab_ff) - 33'(prod_ff[31:0]);
               state_ff <= ST_THR;
            end
            ST_THR: begin
               state_ff <= ST_DEC;
            end
            ST_DEC: begin
               j_ff     <= j_ff + 1'b1;
               state_ff <= ST_RDJ;
            end
            ST_FIN: begin
               rsp_strobe_ff  <= 1'b1;
               rsp_status_ff  <= 1'b0;
               rsp_final_ff   <= 1'b1;
               rsp_present_ff <= pend_valid_ff;
               rsp_class_ff   <= pend_valid_ff ? pend_tag_ff[18:16] : 3'd0;
               rsp_left_ff    <= pend_valid_ff ? pend_box_ff[15:0]  : 16'd0;
               rsp_top_ff     <= pend_valid_ff ? pend_box_ff[31:16] : 16'd0;
               rsp_right_ff   <= pend_valid_ff ? pend_box_ff[47:32] : 16'd0;
               rsp_bottom_ff  <= pend_valid_ff ? pend_box_ff[63:48] : 16'd0;
               rsp_score_ff   <= pend_valid_ff ? pend_tag_ff[15:0]  : 16'd0;
               pend_valid_ff  <= 1'b0;
               loaded_ff      <= '0;
               bad_ff         <= 1'b0;
               kept_ff        <= '0;
               state_ff       <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_present     = rsp_present_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_kept_class  = rsp_class_ff;
   assign rsp_kept_left   = rsp_left_ff;
   assign rsp_kept_top    = rsp_top_ff;
   assign rsp_kept_right  = rsp_right_ff;
   assign rsp_kept_bottom = rsp_bottom_ff;
   assign rsp_kept_score  = rsp_score_ff;
   assign rsp_final_res   = rsp_final_ff;

   a_mid_beat_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_final_res |-> busy) else $error("non-final beat while idle");
   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status |-> !rsp_present) else $error("fail beat carries a box");
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_valid_ff) else $error("pending box left at idle");
   a_loaded_bound: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= CW'(cnms_pkg::MAX_BOXES)) else $error("load count overflow");
   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      kept_ff <= 7'(cnms_pkg::MAX_KEPT)) else $error("kept count overflow");
endmodule
`default_nettype wire
